// ----- src/cocc_pkg.sv -----
package cocc_pkg;

   // Coordinate and radius width of the item fields.
   localparam int COORD_BITS = 10;
   // Default table depth.
   localparam int MAX_OBSTACLES_DEF = 16;

   localparam int OP_BITS = 2;
   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_BITS-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_QUERY = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [OP_BITS-1:0]    operation;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [COORD_BITS-1:0] radius;
   } req_item_type;

   typedef struct packed {
      logic hit;
      logic status;
   } rsp_item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      logic [COORD_BITS-1:0] rad;
   } obst_entry_type;

endpackage

// ----- src/circle_obstacle_collision_checker_top.sv -----
// Circle obstacle collision checker. Keeps a table of up to MAX_OBSTACLES
// circles (centre x, y and radius) in a synchronous single-port-read memory
// and answers one item at a time. Clear and add items finish in the cycle
// they are accepted, their result showing on the next cycle; an add into a
// full table is dropped and reported with status = 1. A query walks the
// stored entries one per cycle through a three-stage read / square /
// compare pipeline and reports hit = 1 when the point lies inside or on any
// stored circle; a query on an empty table is answered like a clear or an
// add. The memory read port, one entry per cycle, sets the scan rate. A new
// item is taken only when no work is in flight and the result register is
// free or being drained in the same cycle. No clearing pass is run after
// reset: entries are read only below the fill count.
module circle_obstacle_collision_checker_top
   import cocc_pkg::*;
#(
   parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int SUM_W = SQ_W + 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OBSTACLES);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             sq_vld_ff, sq_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload
   logic [COORD_BITS-1:0] qx_ff, qx_in;
   logic [COORD_BITS-1:0] qy_ff, qy_in;
   logic                  hit_ff, hit_in;
   rsp_item_type          rsp_ff, rsp_in;
   logic [SQ_W-1:0]       dx2_ff, dx2_in;
   logic [SQ_W-1:0]       dy2_ff, dy2_in;
   logic [SQ_W-1:0]       r2_ff, r2_in;

   // Obstacle memory
   obst_entry_type obst_mem [MAX_OBSTACLES];
   obst_entry_type rd_data_ff;
   logic           wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   obst_entry_type wr_data;

   logic                  accept;
   logic                  slot_free;
   logic                  issue;
   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;
   logic [SUM_W-1:0]      dist2;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Issue one read per cycle while entries remain below the fill count.
   assign issue   = (state_ff == ST_SCAN) && (iss_ff != count_ff);
   assign rd_addr = iss_ff[IDX_W-1:0];
   assign wr_addr = count_ff[IDX_W-1:0];
   assign wr_data = '{cx: req_data.pos_x, cy: req_data.pos_y, rad: req_data.radius};
   assign wr_en   = accept && (req_data.operation == OP_ADD) && (count_ff < CNT_MAX);

   // Stage 2: distances from the stored centre, then exact squares.
   assign dx = (rd_data_ff.cx >= qx_ff) ? (rd_data_ff.cx - qx_ff) : (qx_ff - rd_data_ff.cx);
   assign dy = (rd_data_ff.cy >= qy_ff) ? (rd_data_ff.cy - qy_ff) : (qy_ff - rd_data_ff.cy);
   assign dx2_in = SQ_W'(dx) * SQ_W'(dx);
   assign dy2_in = SQ_W'(dy) * SQ_W'(dy);
   assign r2_in  = SQ_W'(rd_data_ff.rad) * SQ_W'(rd_data_ff.rad);

   // Stage 3: sum and compare; the boundary counts as a hit.
   assign dist2 = {1'b0, dx2_ff} + {1'b0, dy2_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      iss_in       = iss_ff;
      rd_vld_in    = issue;
      sq_vld_in    = rd_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      hit_in       = hit_ff;

      if (sq_vld_ff && (dist2 <= {1'b0, r2_ff})) begin
         hit_in = 1'b1;
      end
      if (issue) begin
         iss_in = iss_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in = '{hit: 1'b0, status: STATUS_OK};
               case (req_data.operation)
                  OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < CNT_MAX) begin
                        count_in = count_ff + 1'b1;
                     end else begin
                        rsp_in.status = STATUS_FULL;
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        qx_in    = req_data.pos_x;
                        qy_in    = req_data.pos_y;
                        hit_in   = 1'b0;
                        iss_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     // unused code: no state change, empty result
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // advance once every entry is read and the pipeline has drained
            if (!issue && !rd_vld_ff && !sq_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_in       = '{hit: hit_ff, status: STATUS_OK};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         iss_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_ff       <= iss_in;
         rd_vld_ff    <= rd_vld_in;
         sq_vld_ff    <= sq_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      qx_ff  <= qx_in;
      qy_ff  <= qy_in;
      hit_ff <= hit_in;
      dx2_ff <= dx2_in;
      dy2_ff <= dy2_in;
      r2_ff  <= r2_in;
   end

   // Obstacle table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         obst_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= obst_mem[rd_addr];
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("obstacle count above table depth");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (iss_ff <= count_ff))
      else $error("read pointer past fill count");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff != '0))
      else $error("scan started on empty table");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!rd_vld_ff && !sq_vld_ff))
      else $error("pipeline busy while idle");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!rd_vld_ff && !sq_vld_ff && (iss_ff == count_ff)))
      else $error("query finished before all entries compared");
`endif

endmodule
